### design/fpgs_pkg.sv
`default_nettype none
package fpgs_pkg;

  localparam int NUM_LABELS = 7;
  localparam int IDX_W      = $clog2(NUM_LABELS);
  localparam int LAB_W      = $clog2(NUM_LABELS);
  localparam int MEM_W      = 17;
  localparam int SPAN_W     = 11;
  localparam int CTR_W      = 15;
  localparam int ACC_W      = 33;
  localparam int WSUM_W     = 19;
  localparam int AVG_W      = 16;
  localparam int GAIN_W     = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd1;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd64;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 8'd16;

  localparam logic [MEM_W-1:0] MEM_ONE = 17'd65536;

  localparam logic signed [15:0] ERR_BP [2][NUM_LABELS] = '{
    '{-16'sd2400, -16'sd1280, -16'sd480, 16'sd0, 16'sd480, 16'sd1280, 16'sd2400},
    '{-16'sd2400, -16'sd1600, -16'sd320, 16'sd0, 16'sd320, 16'sd1600, 16'sd2400}
  };

  localparam logic signed [15:0] RATE_BP [2][NUM_LABELS] = '{
    '{-16'sd192, -16'sd128, -16'sd64, 16'sd0, 16'sd64, 16'sd128, 16'sd192},
    '{-16'sd480, -16'sd240, -16'sd128, 16'sd0, 16'sd128, 16'sd240, 16'sd480}
  };

  localparam logic [CTR_W-1:0] CENTERS [2][NUM_LABELS] = '{
    '{15'd737, 15'd819, 15'd1024, 15'd1229, 15'd1434, 15'd1638, 15'd1966},
    '{15'd10240, 15'd12288, 15'd14336, 15'd15565, 15'd16056, 15'd16179, 15'd16384}
  };

  localparam logic [LAB_W-1:0] RULE_ROM [2][NUM_LABELS][NUM_LABELS] = '{
    '{
      '{3'd6, 3'd5, 3'd4, 3'd4, 3'd2, 3'd1, 3'd1},
      '{3'd5, 3'd4, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1},
      '{3'd4, 3'd3, 3'd2, 3'd2, 3'd0, 3'd1, 3'd1},
      '{3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2},
      '{3'd1, 3'd1, 3'd0, 3'd2, 3'd2, 3'd3, 3'd4},
      '{3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd4, 3'd5},
      '{3'd1, 3'd1, 3'd2, 3'd4, 3'd4, 3'd5, 3'd6}
    },
    '{
      '{3'd6, 3'd5, 3'd4, 3'd3, 3'd5, 3'd6, 3'd6},
      '{3'd5, 3'd4, 3'd3, 3'd2, 3'd5, 3'd5, 3'd6},
      '{3'd5, 3'd4, 3'd3, 3'd1, 3'd5, 3'd5, 3'd5},
      '{3'd4, 3'd3, 3'd1, 3'd0, 3'd1, 3'd3, 3'd4},
      '{3'd5, 3'd5, 3'd5, 3'd1, 3'd3, 3'd4, 3'd5},
      '{3'd6, 3'd5, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5},
      '{3'd6, 3'd6, 3'd5, 3'd3, 3'd4, 3'd5, 3'd6}
    }
  };

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [SPAN_W-1:0] num;
    logic [SPAN_W-1:0] den;
  } fuzz_t;

  function automatic fuzz_t fuzzify(input logic signed [15:0] bp [NUM_LABELS],
                                    input logic signed [15:0] x);
    fuzz_t       f;
    logic        found;
    logic [16:0] d;
    f.idx = IDX_W'(NUM_LABELS - 2);
    f.num = '0;
    d     = 17'(bp[NUM_LABELS-1]) - 17'(bp[NUM_LABELS-2]);
    f.den = d[SPAN_W-1:0];
    found = 1'b0;
    if (x <= bp[0]) begin
      d     = 17'(bp[1]) - 17'(bp[0]);
      f.idx = '0;
      f.den = d[SPAN_W-1:0];
      f.num = d[SPAN_W-1:0];
    end else if (x < bp[NUM_LABELS-1]) begin
      for (int k = 1; k < NUM_LABELS; k++) begin
        if (!found && x <= bp[k]) begin
          found = 1'b1;
          f.idx = IDX_W'(k - 1);
          d     = 17'(bp[k]) - 17'(x);
          f.num = d[SPAN_W-1:0];
          d     = 17'(bp[k]) - 17'(bp[k-1]);
          f.den = d[SPAN_W-1:0];
        end
      end
    end
    return f;
  endfunction

endpackage
`default_nettype wire

### design/fpgs_if.sv
`default_nettype none
interface fpgs_req_if;
  logic               valid;
  logic               ready;
  logic               table_select;
  logic signed [15:0] error;
  logic signed [15:0] error_rate;
  modport source(output valid, table_select, error, error_rate, input ready);
  modport sink(input valid, table_select, error, error_rate, output ready);
endinterface

interface fpgs_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] gain;
  modport source(output valid, gain, input ready);
  modport sink(input valid, gain, output ready);
endinterface
`default_nettype wire

### design/fuzzy_pd_gain_scheduler_top.sv
// Throughput: one request per cycle; the whole pipeline advances together
// and holds while the result register waits to be taken.
// Bit-per-stage dividers: two of 17 stages (membership), one of 16 (average).
// Reset: asynchronous active low; clears valid bits and loads gains 4.0 / 1.0.
`default_nettype none
module fuzzy_pd_gain_scheduler_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fpgs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fpgs_pkg::GAIN_W-1:0]    cfg_data_i,
  fpgs_req_if.sink                            req_i,
  fpgs_rsp_if.source                          rsp_o
);
  import fpgs_pkg::*;

  logic              en;
  logic [GAIN_W-1:0] prop_gain_q;
  logic [GAIN_W-1:0] deriv_gain_q;

  logic               v1_q;
  logic               sel1_q;
  logic signed [15:0] e1_q;
  logic signed [15:0] r1_q;

  logic  v2_q;
  logic  sel2_q;
  fuzz_t fe2_q;
  fuzz_t fr2_q;
  fuzz_t fe2_d;
  fuzz_t fr2_d;

  logic             dve_v;
  logic             dvr_v;
  logic [MEM_W-1:0] pe0;
  logic [MEM_W-1:0] pr0;
  logic             sel_dv;
  logic [IDX_W-1:0] ei_dv;
  logic [IDX_W-1:0] ri_dv;

  logic             v3_q;
  logic             sel3_q;
  logic [LAB_W-1:0] lab3_q [4];
  logic [MEM_W-1:0] w3_q   [4];
  logic [MEM_W-1:0] pe1;
  logic [MEM_W-1:0] pr1;

  logic             v4_q;
  logic             sel4_q;
  logic [LAB_W-1:0] lab4_q [4];
  logic [MEM_W-1:0] w4_q   [4];
  logic [MEM_W-1:0] w4_d   [4];

  logic              v5_q;
  logic              sel5_q;
  logic [31:0]       prod5_q [4];
  logic [WSUM_W-1:0] den5_q;

  logic [ACC_W+1:0]  dividend;
  logic              dva_v;
  logic [AVG_W-1:0]  avg;
  logic [1:0]        side_a;
  logic [GAIN_W-1:0] gsel;
  logic [23:0]       scaled;

  logic        out_v_q;
  logic [15:0] out_gain_q;

  assign en          = !out_v_q || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PROP_GAIN) begin
        prop_gain_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_DERIV_GAIN) begin
        deriv_gain_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= dve_v && dvr_v;
      v4_q <= v3_q;
      v5_q <= v4_q;
      out_v_q <= dva_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel1_q <= req_i.table_select;
      e1_q   <= req_i.error;
      r1_q   <= req_i.error_rate;
    end
  end

  always_comb begin
    fe2_d = fuzzify(ERR_BP[sel1_q], e1_q);
    fr2_d = fuzzify(RATE_BP[sel1_q], r1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel2_q <= sel1_q;
      fe2_q  <= fe2_d;
      fr2_q  <= fr2_d;
    end
  end

  fpgs_div #(.QW(MEM_W), .DW(SPAN_W), .SW(IDX_W + 1)) u_div_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v2_q),
    .dividend_i ({1'b0, fe2_q.num, 16'd0} + (MEM_W + SPAN_W)'(fe2_q.den >> 1)),
    .divisor_i  (fe2_q.den),
    .side_i     ({sel2_q, fe2_q.idx}),
    .valid_o    (dve_v),
    .quotient_o (pe0),
    .side_o     ({sel_dv, ei_dv})
  );

  fpgs_div #(.QW(MEM_W), .DW(SPAN_W), .SW(IDX_W)) u_div_rate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v2_q),
    .dividend_i ({1'b0, fr2_q.num, 16'd0} + (MEM_W + SPAN_W)'(fr2_q.den >> 1)),
    .divisor_i  (fr2_q.den),
    .side_i     (fr2_q.idx),
    .valid_o    (dvr_v),
    .quotient_o (pr0),
    .side_o     (ri_dv)
  );

  assign pe1 = MEM_ONE - pe0;
  assign pr1 = MEM_ONE - pr0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel3_q    <= sel_dv;
      lab3_q[0] <= RULE_ROM[sel_dv][ei_dv][ri_dv];
      lab3_q[1] <= RULE_ROM[sel_dv][ei_dv + 1'b1][ri_dv];
      lab3_q[2] <= RULE_ROM[sel_dv][ei_dv][ri_dv + 1'b1];
      lab3_q[3] <= RULE_ROM[sel_dv][ei_dv + 1'b1][ri_dv + 1'b1];
      w3_q[0]   <= (pe0 <= pr0) ? pe0 : pr0;
      w3_q[1]   <= (pe1 <= pr0) ? pe1 : pr0;
      w3_q[2]   <= (pe0 <= pr1) ? pe0 : pr1;
      w3_q[3]   <= (pe1 <= pr1) ? pe1 : pr1;
    end
  end

  always_comb begin
    w4_d = w3_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (lab3_q[i] == lab3_q[j]) begin
          if (w4_d[i] > w4_d[j]) begin
            w4_d[j] = '0;
          end else begin
            w4_d[i] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel4_q <= sel3_q;
      lab4_q <= lab3_q;
      w4_q   <= w4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel5_q <= sel4_q;
      for (int i = 0; i < 4; i++) begin
        prod5_q[i] <= 32'(w4_q[i]) * 32'(CENTERS[sel4_q][lab4_q[i]]);
      end
      den5_q <= WSUM_W'(w4_q[0]) + WSUM_W'(w4_q[1]) + WSUM_W'(w4_q[2])
              + WSUM_W'(w4_q[3]);
    end
  end

  assign dividend = (ACC_W + 2)'(prod5_q[0]) + (ACC_W + 2)'(prod5_q[1])
                  + (ACC_W + 2)'(prod5_q[2]) + (ACC_W + 2)'(prod5_q[3])
                  + (ACC_W + 2)'(den5_q >> 1);

  fpgs_div #(.QW(AVG_W), .DW(WSUM_W), .SW(2)) u_div_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v5_q),
    .dividend_i (dividend),
    .divisor_i  (den5_q),
    .side_i     ({sel5_q, den5_q == '0}),
    .valid_o    (dva_v),
    .quotient_o (avg),
    .side_o     (side_a)
  );

  assign gsel   = side_a[1] ? deriv_gain_q : prop_gain_q;
  assign scaled = 24'(avg) * 24'(gsel) + 24'd8;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side_a[0]) begin
        out_gain_q <= '0;
      end else if (scaled[23:20] != 4'd0) begin
        out_gain_q <= 16'hFFFF;
      end else begin
        out_gain_q <= scaled[19:4];
      end
    end
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.gain  = out_gain_q;

endmodule
`default_nettype wire

### design/fpgs_div.sv
`default_nettype none
module fpgs_div #(
  parameter int QW = 17,
  parameter int DW = 11,
  parameter int SW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [QW+DW-1:0] dividend_i,
  input  wire logic [DW-1:0]    divisor_i,
  input  wire logic [SW-1:0]    side_i,
  output logic                  valid_o,
  output logic [QW-1:0]         quotient_o,
  output logic [SW-1:0]         side_o
);

  logic          vld_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] dvs_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = dividend_i[QW+DW-1:QW];
      assign low_in  = dividend_i[QW-1:0];
      assign quo_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign low_in  = low_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_q[s]  <= {low_in[QW-2:0], 1'b0};
        quo_q[s]  <= {quo_in[QW-2:0], ge};
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o    = vld_q[QW-1];
  assign quotient_o = quo_q[QW-1];
  assign side_o     = side_q[QW-1];

endmodule
`default_nettype wire
